@@ rtl/core/thfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame decoder package
// Shared types, constants and the CRC-8 byte update used by the frame decoder
// and its checker.
// ----------------------------------------------------------------------------
package thfd_pkg;

    // CRC-8 with polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR.
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;

    // Fixed-point conversion constants.
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;

    // Product widths: 17500 * 65535 fits in 31 bits, 10000 * 65535 in 30.
    localparam int TPROD_W = 31;
    localparam int HPROD_W = 30;

    // Frame status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
    localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } frame_in_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic        [13:0] humidity_centi;
        logic        [15:0] raw_temperature;
        logic        [15:0] raw_humidity;
        logic        [1:0]  frame_status;
    } frame_out_t;

    // Folds one byte into the running CRC, one bit per step.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/temp_humidity_frame_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The frame register loads on the edge that transfers a frame's sixth byte, then the
// multiply register and the result register follow; m_valid rises with the result register.
// Throughput: one byte per cycle; the input stalls only when the frame, multiply and
// result registers all hold a frame and m_ready is low.
// Reset: synchronous, active low; clears the byte count, the running CRC and
// all valid flags, so no partial frame survives a reset.
// ----------------------------------------------------------------------------
// Temperature and humidity frame decoder
// Collects the six bytes of a sensor measurement frame, checks both CRC-8
// fields and converts the raw words to hundredths of a degree and a percent.
// ----------------------------------------------------------------------------
module temp_humidity_frame_decoder_core (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  thfd_pkg::frame_in_t   s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output thfd_pkg::frame_out_t  m_data
);
    import thfd_pkg::*;

    // Positions of the bytes within a frame.
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // ------------------------------------------------------------------
    // Frame assembly state.
    // ------------------------------------------------------------------
    logic [2:0]  pos_reg,      pos_next;
    logic [7:0]  crc_reg,      crc_next;
    logic        tcrc_bad_reg, tcrc_bad_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] hum_word_reg,  hum_word_next;

    // Stage 1: one complete frame waiting for conversion.
    logic        s1_valid_reg;
    logic [15:0] s1_temp_reg;
    logic [15:0] s1_hum_reg;
    logic [1:0]  s1_status_reg;
    logic [1:0]  status_next;
    logic        frame_done;

    // Stage 2: scaled products.
    logic                s2_valid_reg;
    logic [TPROD_W-1:0]  s2_tprod_reg;
    logic [HPROD_W-1:0]  s2_hprod_reg;
    logic [15:0]         s2_temp_reg;
    logic [15:0]         s2_hum_reg;
    logic [1:0]          s2_status_reg;

    // Stage 3: output register.
    logic        m_valid_reg;
    frame_out_t  m_data_reg;
    frame_out_t  m_data_next;

    // Per-stage readiness: a stage may load when it is empty or is handing
    // its contents on in the same cycle.
    logic ready3, ready2, ready1;
    logic s_xfer;

    logic [2:0]  pos_eff;
    logic [7:0]  crc_upd;

    // Division by 65535 without a divider: with q0 = x >> 16 the remainder of
    // x - q0 * 65535 is x[15:0] + q0, which stays below twice the divisor, so
    // a single compare adds the missing unit to the quotient.
    logic [16:0] t_rem;
    logic [14:0] t_quot;
    logic [16:0] h_rem;
    logic [13:0] h_quot;

    assign ready3  = !m_valid_reg || m_ready;
    assign ready2  = !s2_valid_reg || ready3;
    assign ready1  = !s1_valid_reg || ready2;
    assign s_ready = ready1;
    assign s_xfer  = s_valid && ready1;

    // A frame-start flag always makes this byte the first of a frame; the
    // unused counts six and seven are treated the same way.
    assign pos_eff = (s_data.frame_start || pos_reg > POS_HUM_CRC) ? POS_TEMP_HI : pos_reg;
    assign crc_upd = crc8_update((pos_eff == POS_TEMP_HI || pos_eff == POS_HUM_HI)
                                 ? CRC_INIT : crc_reg, s_data.frame_byte);

    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        tcrc_bad_next  = tcrc_bad_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        frame_done     = 1'b0;
        if (s_xfer) begin
            unique case (pos_eff)
                POS_TEMP_HI: begin
                    temp_word_next = {s_data.frame_byte, 8'h00};
                    crc_next       = crc_upd;
                    pos_next       = POS_TEMP_LO;
                end
                POS_TEMP_LO: begin
                    temp_word_next = {temp_word_reg[15:8], s_data.frame_byte};
                    crc_next       = crc_upd;
                    pos_next       = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    tcrc_bad_next = (s_data.frame_byte != crc_reg);
                    crc_next      = CRC_INIT;
                    pos_next      = POS_HUM_HI;
                end
                POS_HUM_HI: begin
                    hum_word_next = {s_data.frame_byte, 8'h00};
                    crc_next      = crc_upd;
                    pos_next      = POS_HUM_LO;
                end
                POS_HUM_LO: begin
                    hum_word_next = {hum_word_reg[15:8], s_data.frame_byte};
                    crc_next      = crc_upd;
                    pos_next      = POS_HUM_CRC;
                end
                default: begin
                    // Last byte: the humidity CRC closes the frame.
                    frame_done = 1'b1;
                    crc_next   = CRC_INIT;
                    pos_next   = POS_TEMP_HI;
                end
            endcase
        end
    end

    // The temperature check takes precedence when both CRCs are wrong.
    always_comb begin
        if (tcrc_bad_reg) begin
            status_next = STATUS_TEMP_CRC;
        end else if (s_data.frame_byte != crc_reg) begin
            status_next = STATUS_HUM_CRC;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_comb begin
        t_rem  = {1'b0, s2_tprod_reg[15:0]} + 17'(s2_tprod_reg[TPROD_W-1:16]);
        t_quot = s2_tprod_reg[TPROD_W-1:16] + 15'(t_rem >= 17'(FULL_SCALE));
        h_rem  = {1'b0, s2_hprod_reg[15:0]} + 17'(s2_hprod_reg[HPROD_W-1:16]);
        h_quot = s2_hprod_reg[HPROD_W-1:16] + 14'(h_rem >= 17'(FULL_SCALE));

        // Subtracting the offset modulo 2^15 yields the two's complement value.
        m_data_next.temperature_centi = $signed(t_quot - TEMP_OFFSET);
        m_data_next.humidity_centi    = h_quot;
        m_data_next.raw_temperature   = s2_temp_reg;
        m_data_next.raw_humidity      = s2_hum_reg;
        m_data_next.frame_status      = s2_status_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_TEMP_HI;
            crc_reg      <= CRC_INIT;
            tcrc_bad_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            tcrc_bad_reg <= tcrc_bad_next;
            if (ready1) begin
                s1_valid_reg <= frame_done;
            end
            if (ready2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        temp_word_reg <= temp_word_next;
        hum_word_reg  <= hum_word_next;
        if (ready1 && frame_done) begin
            s1_temp_reg   <= temp_word_reg;
            s1_hum_reg    <= hum_word_reg;
            s1_status_reg <= status_next;
        end
        if (ready2 && s1_valid_reg) begin
            s2_tprod_reg  <= TPROD_W'(s1_temp_reg) * TPROD_W'(TEMP_SPAN);
            s2_hprod_reg  <= HPROD_W'(s1_hum_reg) * HPROD_W'(HUM_SPAN);
            s2_temp_reg   <= s1_temp_reg;
            s2_hum_reg    <= s1_hum_reg;
            s2_status_reg <= s1_status_reg;
        end
        if (ready3 && s2_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/thfd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame decoder checker
// Port-level assertions on the result channel, bound to the decoder core.
// ----------------------------------------------------------------------------
module thfd_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  m_valid,
    input wire                  m_ready,
    input thfd_pkg::frame_out_t m_data
);
    import thfd_pkg::*;

    // A stalled result holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.frame_status == STATUS_OK ||
                     m_data.frame_status == STATUS_TEMP_CRC ||
                     m_data.frame_status == STATUS_HUM_CRC))
        else $error("undefined frame status");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.temperature_centi >= -15'sd4500 &&
                    m_data.temperature_centi <= 15'sd13000)
        else $error("temperature out of range");

    a_hum_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.raw_humidity == FULL_SCALE |->
            m_data.humidity_centi == HUM_SPAN)
        else $error("full-scale humidity not converted to 100 percent");

    a_temp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.raw_temperature == 16'h0000 |->
            m_data.temperature_centi == -15'sd4500)
        else $error("zero temperature word not converted to the offset");

endmodule

bind temp_humidity_frame_decoder_core thfd_checker u_thfd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

@@ dv/temp_humidity_frame_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame decoder testbench
// Streams measurement frames, broken frames and loose bytes into the decoder
// under random idling on both channels. Each transfer is also decoded by a
// behavioural copy of the block, and every reading is checked field by field.
// ----------------------------------------------------------------------------
module temp_humidity_frame_decoder_core_test;
    import thfd_pkg::*;

    localparam int IDLE_LIMIT   = 2000; // cycles without any transfer
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int DRAIN_CYCLES = 12;   // settle time after the last reading

    // Byte positions within a measurement frame.
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    frame_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    frame_out_t m_data;

    // Decoder state as the testbench sees it.
    logic [2:0]  dec_pos       = POS_TEMP_HI;
    logic [7:0]  dec_crc       = CRC_INIT;
    logic [15:0] dec_temp_word = '0;
    logic [15:0] dec_hum_word  = '0;
    logic        dec_temp_bad  = 1'b0;

    frame_out_t pending_readings[$];
    frame_out_t oldest_reading;
    int         mismatch_count = 0;
    int         idle_cycles    = 0;

    // Idling controls: a calm side never idles; hold_request asks the
    // receiver for one long hold-off.
    bit tx_calm      = 1'b0;
    bit rx_calm      = 1'b0;
    bit hold_request = 1'b0;

    temp_humidity_frame_decoder_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Bit-serial CRC-8, polynomial 0x31, most significant bit first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = r << 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Advances the decoder state by one accepted byte and, on the sixth byte
    // of a frame, queues the reading that the block must produce.
    function automatic void decode_frame_byte(input frame_in_t item);
        logic [2:0]  slot;
        logic [31:0] t_scaled;
        logic [31:0] h_scaled;
        frame_out_t  reading;
        slot = dec_pos;
        // A start flag, or a position outside the frame, restarts at byte 0.
        if (item.frame_start || slot > POS_HUM_CRC) begin
            slot = POS_TEMP_HI;
        end
        case (slot)
            POS_TEMP_HI: begin
                dec_temp_word = {item.frame_byte, 8'h00};
                dec_crc       = crc8_fold(CRC_INIT, item.frame_byte);
                dec_pos       = POS_TEMP_LO;
            end
            POS_TEMP_LO: begin
                dec_temp_word = {dec_temp_word[15:8], item.frame_byte};
                dec_crc       = crc8_fold(dec_crc, item.frame_byte);
                dec_pos       = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
                dec_temp_bad = (item.frame_byte != dec_crc);
                dec_crc      = CRC_INIT;
                dec_pos      = POS_HUM_HI;
            end
            POS_HUM_HI: begin
                dec_hum_word = {item.frame_byte, 8'h00};
                dec_crc      = crc8_fold(CRC_INIT, item.frame_byte);
                dec_pos      = POS_HUM_LO;
            end
            POS_HUM_LO: begin
                dec_hum_word = {dec_hum_word[15:8], item.frame_byte};
                dec_crc      = crc8_fold(dec_crc, item.frame_byte);
                dec_pos      = POS_HUM_CRC;
            end
            default: begin
                // The temperature check wins when both words are corrupt.
                if (dec_temp_bad) begin
                    reading.frame_status = STATUS_TEMP_CRC;
                end else if (item.frame_byte != dec_crc) begin
                    reading.frame_status = STATUS_HUM_CRC;
                end else begin
                    reading.frame_status = STATUS_OK;
                end
                // Floor the quotient first, then apply the offset, so that
                // negative temperatures step towards minus infinity.
                t_scaled = (32'(TEMP_SPAN) * 32'(dec_temp_word)) / 32'(FULL_SCALE);
                h_scaled = (32'(HUM_SPAN) * 32'(dec_hum_word)) / 32'(FULL_SCALE);
                reading.temperature_centi = 15'(t_scaled - 32'(TEMP_OFFSET));
                reading.humidity_centi    = h_scaled[13:0];
                reading.raw_temperature   = dec_temp_word;
                reading.raw_humidity      = dec_hum_word;
                pending_readings.push_back(reading);
                dec_pos = POS_TEMP_HI;
                dec_crc = CRC_INIT;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offers one byte after a random gap and returns at the edge of its
    // transfer. The next call follows in the same time step, so valid only
    // drops when a gap is drawn.
    task automatic send_byte(input logic [7:0] data, input logic start);
        int        gap;
        logic      took;
        frame_in_t item;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.frame_byte  = data;
        item.frame_start = start;
        s_valid <= 1'b1;
        s_data  <= item;
        // Ready is sampled mid-cycle, where nothing is changing.
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        decode_frame_byte(item);
    endtask

    // Sends a complete frame; a CRC that is to fail is flipped in some bits.
    task automatic send_frame(input logic [15:0] temp_word, input logic [15:0] hum_word,
                              input logic start, input logic temp_ok, input logic hum_ok);
        logic [7:0] temp_crc;
        logic [7:0] hum_crc;
        temp_crc = crc8_fold(crc8_fold(CRC_INIT, temp_word[15:8]), temp_word[7:0]);
        hum_crc  = crc8_fold(crc8_fold(CRC_INIT, hum_word[15:8]), hum_word[7:0]);
        if (!temp_ok) begin
            temp_crc = temp_crc ^ 8'($urandom_range(1, 255));
        end
        if (!hum_ok) begin
            hum_crc = hum_crc ^ 8'($urandom_range(1, 255));
        end
        send_byte(temp_word[15:8], start);
        send_byte(temp_word[7:0], 1'b0);
        send_byte(temp_crc, 1'b0);
        send_byte(hum_word[15:8], 1'b0);
        send_byte(hum_word[7:0], 1'b0);
        send_byte(hum_crc, 1'b0);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Extremes of both words, each status code, a frame without its start
    // flag, a restart in the middle of a frame and the smallest negative
    // step of the temperature conversion.
    task automatic test_directed_frames();
        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h0001, 16'h0001, 1'b1, 1'b1, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b0);
    endtask

    // Mostly well-formed frames with random content, mixed with truncated
    // frames and loose bytes. The idling modes change now and then.
    task automatic test_random_traffic();
        int kind;
        int count;
        for (int n = 0; n < 110; n++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                send_frame(pick_word(), pick_word(), ($urandom_range(0, 7) != 0),
                           ($urandom_range(0, 5) != 0), ($urandom_range(0, 5) != 0));
            end else if (kind == 7) begin
                count = $urandom_range(1, 5);
                for (int k = 0; k < count; k++) begin
                    send_byte(8'($urandom), (k == 0));
                end
            end else if (kind == 8) begin
                count = $urandom_range(1, 8);
                for (int k = 0; k < count; k++) begin
                    send_byte(8'($urandom), 1'($urandom));
                end
            end else begin
                tx_calm = ($urandom_range(0, 2) == 0);
                rx_calm = ($urandom_range(0, 2) == 0);
                send_frame(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1);
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // The receiver holds off for a long stretch while frames keep coming
    // back to back, so the block fills and stops accepting bytes.
    task automatic test_output_stall();
        tx_calm      = 1'b1;
        hold_request = 1'b1;
        for (int n = 0; n < 10; n++) begin
            send_frame(pick_word(), pick_word(), 1'b1, 1'b1, ($urandom_range(0, 3) != 0));
        end
        tx_calm = 1'b0;
    endtask

    // Result channel: a random wait before each transfer, unless told to
    // hold off for a long stretch.
    initial begin : result_sink
        int   pause;
        logic fired;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            pause = rx_calm ? 0 : $urandom_range(0, 18);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                fired = m_valid;
                @(posedge aclk);
            end while (!fired && !hold_request);
        end
    end

    // Each reading is compared with the oldest one still pending.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("reading with none pending, raw_temperature",
                                32'(m_data.raw_temperature), -1);
            end else begin
                oldest_reading = pending_readings.pop_front();
                if (m_data.temperature_centi !== oldest_reading.temperature_centi) begin
                    report_mismatch("temperature_centi", 32'(m_data.temperature_centi),
                                    32'(oldest_reading.temperature_centi));
                end
                if (m_data.humidity_centi !== oldest_reading.humidity_centi) begin
                    report_mismatch("humidity_centi", 32'(m_data.humidity_centi),
                                    32'(oldest_reading.humidity_centi));
                end
                if (m_data.raw_temperature !== oldest_reading.raw_temperature) begin
                    report_mismatch("raw_temperature", 32'(m_data.raw_temperature),
                                    32'(oldest_reading.raw_temperature));
                end
                if (m_data.raw_humidity !== oldest_reading.raw_humidity) begin
                    report_mismatch("raw_humidity", 32'(m_data.raw_humidity),
                                    32'(oldest_reading.raw_humidity));
                end
                if (m_data.frame_status !== oldest_reading.frame_status) begin
                    report_mismatch("frame_status", 32'(m_data.frame_status),
                                    32'(oldest_reading.frame_status));
                end
            end
        end
    end

    // Watchdog: ends the run once too many cycles pass without a transfer.
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("temp_humidity_frame_decoder_core_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_frames();
        test_random_traffic();
        test_output_stall();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("temp_humidity_frame_decoder_core_test: clean");
        end else begin
            $display("temp_humidity_frame_decoder_core_test: errors");
        end
        $finish;
    end

endmodule
